@@ src/csfw_pkg.sv @@
// ----------------------------------------------------------------------------
// csfw_pkg
// Shared types and codes for the counting semaphore with a FIFO of waiters.
// ----------------------------------------------------------------------------
package csfw_pkg;

  localparam int CMD_W   = 2;
  localparam int ID_W    = 8;
  localparam int KIND_W  = 3;
  localparam int COUNT_W = 16;
  localparam int INIT_W  = 15;

  // command codes
  localparam logic [CMD_W-1:0] CMD_WAIT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SIGNAL = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLOSE  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd3;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_PROCEED   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_BLOCKED   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_REL_SIG   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_REL_CLOSE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SIG_DONE  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_ERROR     = 3'd5;
  localparam logic [KIND_W-1:0] KIND_REPORT    = 3'd6;

  localparam logic signed [COUNT_W-1:0] COUNT_MAX = 16'sh7FFF;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [ID_W-1:0]  thread_id;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]         kind;
    logic [ID_W-1:0]           woken_id;
    logic signed [COUNT_W-1:0] count_value;
    logic                      last;
  } out_item_t;

  // queue control from the sequencer
  typedef struct packed {
    logic            push;
    logic            pop;
    logic [ID_W-1:0] push_id;
  } queue_ctl_t;

  // queue status back to the sequencer
  typedef struct packed {
    logic            empty;
    logic            full;
    logic [ID_W-1:0] pop_id;
  } queue_stat_t;

endpackage

@@ src/csfw_wait_queue.sv @@
// ----------------------------------------------------------------------------
// csfw_wait_queue
// Circular FIFO of waiting thread ids held in a synchronous memory. A pop
// returns the oldest id on pop_id in the cycle after the pop.
// ----------------------------------------------------------------------------
module csfw_wait_queue
  import csfw_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  queue_ctl_t  ctl,
  output queue_stat_t stat
);

  localparam int HEAD_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W  = HEAD_W + 1;

  logic [ID_W-1:0]   mem [QUEUE_DEPTH];
  logic [ID_W-1:0]   rd_data;
  logic [HEAD_W-1:0] head;
  logic [HEAD_W-1:0] head_next;
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_next;
  logic [SUM_W-1:0]  tail_sum;
  logic [HEAD_W-1:0] tail;

  // tail = (head + fill) mod depth; the sum stays below twice the depth
  always_comb begin
    tail_sum = {1'b0, head} + SUM_W'(fill);
    if (tail_sum >= SUM_W'(QUEUE_DEPTH)) begin
      tail = HEAD_W'(tail_sum - SUM_W'(QUEUE_DEPTH));
    end else begin
      tail = HEAD_W'(tail_sum);
    end
  end

  always_comb begin
    head_next = head;
    fill_next = fill;
    if (ctl.pop) begin
      head_next = (head == HEAD_W'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
      fill_next = fill - 1'b1;
    end else if (ctl.push) begin
      fill_next = fill + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      fill <= '0;
    end else begin
      head <= head_next;
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[tail] <= ctl.push_id;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pop) begin
      rd_data <= mem[head];
    end
  end

  assign stat.empty  = (fill == '0);
  assign stat.full   = (fill == FILL_W'(QUEUE_DEPTH));
  assign stat.pop_id = rd_data;

endmodule

@@ src/counting_semaphore_fifo_waiters.sv @@
// ----------------------------------------------------------------------------
// counting_semaphore_fifo_waiters
// Counting semaphore with a FIFO of waiting thread ids.
//
//   channel   signals                      direction  transaction when
//   command   start, busy, item            in         start && !busy
//   result    done, result                 out        done (one cycle)
//   config    cfg_we, cfg_data             in         cfg_we
//
// Wait, read, a close with no waiters and a signal that releases nobody:
// busy stays low, the result appears in the cycle after the command and the
// next command may follow at once. A signal that releases a waiter reads the
// queue memory: busy in ST_POP, result once the read returns. A close
// with waiters drains one memory read per cycle: busy while it drains,
// one result per cycle. Synchronous reset clears count, queue pointers and
// initial_count to zero. Results cannot be stalled.
// ----------------------------------------------------------------------------
module counting_semaphore_fifo_waiters
  import csfw_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  in_item_t          item,
  input  logic              cfg_we,
  input  logic [INIT_W-1:0] cfg_data,
  output logic              done,
  output out_item_t         result
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_POP   = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t                    state;
  state_t                    state_next;
  logic [INIT_W-1:0]         initial_count;
  logic signed [COUNT_W-1:0] count;
  logic signed [COUNT_W-1:0] count_next;
  logic signed [COUNT_W-1:0] count_up;
  logic                      done_next;
  out_item_t                 result_next;
  queue_ctl_t                qctl;
  queue_stat_t               qstat;
  logic                      accept;

  csfw_wait_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .ctl  (qctl),
    .stat (qstat)
  );

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign count_up = count + 16'sd1;

  always_comb begin
    state_next  = state;
    count_next  = count;
    done_next   = 1'b0;
    result_next = '{kind: KIND_REPORT, woken_id: '0, count_value: count, last: 1'b1};
    qctl        = '{push: 1'b0, pop: 1'b0, push_id: item.thread_id};

    case (state)
      ST_IDLE: begin
        if (accept) begin
          done_next = 1'b1;
          case (item.cmd)
            CMD_WAIT: begin
              if (count <= 16'sd0) begin
                if (qstat.full) begin
                  result_next.kind = KIND_ERROR;
                end else begin
                  count_next       = count - 16'sd1;
                  qctl.push        = 1'b1;
                  result_next.kind = KIND_BLOCKED;
                end
              end else begin
                count_next       = count - 16'sd1;
                result_next.kind = KIND_PROCEED;
              end
            end
            CMD_SIGNAL: begin
              if (count == COUNT_MAX) begin
                result_next.kind = KIND_ERROR;
              end else begin
                count_next = count_up;
                if (count_up <= 16'sd0) begin
                  if (qstat.empty) begin
                    // keep the raised count and report the missing waiter
                    result_next.kind = KIND_ERROR;
                  end else begin
                    // result follows once the memory read returns
                    qctl.pop   = 1'b1;
                    done_next  = 1'b0;
                    state_next = ST_POP;
                  end
                end else begin
                  result_next.kind = KIND_SIG_DONE;
                end
              end
            end
            CMD_CLOSE: begin
              count_next = {1'b0, initial_count};
              if (qstat.empty) begin
                result_next.kind = KIND_REPORT;
              end else begin
                qctl.pop   = 1'b1;
                done_next  = 1'b0;
                state_next = ST_DRAIN;
              end
            end
            default: begin
              result_next.kind = KIND_REPORT;
            end
          endcase
          result_next.count_value = count_next;
        end
      end
      ST_POP: begin
        done_next   = 1'b1;
        result_next = '{kind: KIND_REL_SIG, woken_id: qstat.pop_id,
                        count_value: count, last: 1'b1};
        state_next  = ST_IDLE;
      end
      ST_DRAIN: begin
        done_next   = 1'b1;
        result_next = '{kind: KIND_REL_CLOSE, woken_id: qstat.pop_id,
                        count_value: count, last: qstat.empty};
        // issue the next read while this one is reported
        if (qstat.empty) begin
          state_next = ST_IDLE;
        end else begin
          qctl.pop = 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      count         <= '0;
      initial_count <= '0;
      done          <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
      if (cfg_we) begin
        initial_count <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done_next) begin
      result <= result_next;
    end
  end

endmodule

@@ verif/tb_counting_semaphore_fifo_waiters.sv @@
// ----------------------------------------------------------------------------
// tb_counting_semaphore_fifo_waiters
// Self-checking bench for the counting semaphore with a FIFO of waiters.
// A clocked driver issues commands from a backlog filled by the stimulus
// block, mirrors every accepted command in a local semaphore model, and a
// clocked monitor compares each reply against the oldest predicted one.
// Directed corner cases come first, then weighted random batches under
// several initial_count settings, with random gaps between commands in most batches.
// ----------------------------------------------------------------------------
module tb_counting_semaphore_fifo_waiters
  import csfw_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QDEPTH      = 16;
  localparam int CYCLE_LIMIT = 200000;

  logic              clk      = 1'b0;
  logic              rst      = 1'b1;
  logic              start    = 1'b0;
  logic              busy;
  in_item_t          item     = '0;
  logic              cfg_we   = 1'b0;
  logic [INIT_W-1:0] cfg_data = '0;
  logic              done;
  out_item_t         result;

  counting_semaphore_fifo_waiters #(.QUEUE_DEPTH(QDEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .item     (item),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .done     (done),
    .result   (result)
  );

  always #1 clk = ~clk;

  // semaphore mirror
  int                sem_count;
  logic [INIT_W-1:0] init_reg;
  logic [ID_W-1:0]   waiters[$];

  in_item_t  cmd_backlog[$];
  out_item_t replies_due[$];

  int gap_left;
  bit gaps_on;
  int cycles;
  int fails;
  int cmds_taken;
  int replies_seen;
  int kind_seen[7];

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void queue_reply(logic [KIND_W-1:0] k, logic [ID_W-1:0] id,
                                      logic fin);
    out_item_t r;
    r.kind        = k;
    r.woken_id    = id;
    r.count_value = COUNT_W'(sem_count);
    r.last        = fin;
    replies_due = {replies_due, r};
  endfunction

  // take the oldest waiter off the mirror queue
  function automatic logic [ID_W-1:0] take_waiter();
    logic [ID_W-1:0] id;
    id = waiters[0];
    waiters.delete(0);
    return id;
  endfunction

  function automatic void apply_sem_cmd(in_item_t c);
    int n;
    case (c.cmd)
      CMD_WAIT: begin
        if (sem_count <= 0) begin
          if (waiters.size() >= QDEPTH) begin
            queue_reply(KIND_ERROR, '0, 1'b1);
          end else begin
            sem_count--;
            waiters = {waiters, c.thread_id};
            queue_reply(KIND_BLOCKED, '0, 1'b1);
          end
        end else begin
          sem_count--;
          queue_reply(KIND_PROCEED, '0, 1'b1);
        end
      end
      CMD_SIGNAL: begin
        if (sem_count >= int'(COUNT_MAX)) begin
          queue_reply(KIND_ERROR, '0, 1'b1);
        end else begin
          sem_count++;
          if (sem_count > 0) queue_reply(KIND_SIG_DONE, '0, 1'b1);
          else if (waiters.size() == 0) queue_reply(KIND_ERROR, '0, 1'b1);
          else queue_reply(KIND_REL_SIG, take_waiter(), 1'b1);
        end
      end
      CMD_CLOSE: begin
        n = waiters.size();
        sem_count = int'(init_reg);
        if (n == 0) queue_reply(KIND_REPORT, '0, 1'b1);
        for (int k = 0; k < n; k++)
          queue_reply(KIND_REL_CLOSE, take_waiter(), k == n - 1);
      end
      default: queue_reply(KIND_REPORT, '0, 1'b1);
    endcase
  endfunction

  // driver: hold start while busy, otherwise insert a gap or advance to the next command
  always @(posedge clk) begin
    if (rst) begin
      start     <= 1'b0;
      item      <= '0;
      gap_left  = 0;
      sem_count = 0;
      init_reg  = '0;
      waiters.delete();
    end else begin
      if (cfg_we) init_reg = cfg_data;
      if (start && !busy) begin
        apply_sem_cmd(item);
        cmds_taken++;
      end
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
          item  <= in_item_t'($urandom);
        end else if (cmd_backlog.size() > 0) begin
          item     <= cmd_backlog[0];
          cmd_backlog.delete(0);
          start    <= 1'b1;
          gap_left = pick_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && done) begin
      replies_seen++;
      if (result.kind < 7) kind_seen[result.kind]++;
      if (replies_due.size() == 0) begin
        $display("%0t: unexpected reply kind %0d id %0d count %0d last %0b", $time,
                 result.kind, result.woken_id, result.count_value, result.last);
        fails++;
      end else begin
        want = replies_due[0];
        replies_due.delete(0);
        if (result.kind !== want.kind || result.woken_id !== want.woken_id ||
            result.count_value !== want.count_value || result.last !== want.last) begin
          $display("%0t: expected kind %0d id %0d count %0d last %0b", $time,
                   want.kind, want.woken_id, want.count_value, want.last);
          $display("%0t:   actual kind %0d id %0d count %0d last %0b", $time,
                   result.kind, result.woken_id, result.count_value, result.last);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("run stopped after %0d cycles, %0d replies outstanding",
               cycles, replies_due.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic void push_cmd(logic [CMD_W-1:0] c, logic [ID_W-1:0] id);
    in_item_t it;
    it.cmd       = c;
    it.thread_id = id;
    cmd_backlog = {cmd_backlog, it};
  endfunction

  task automatic settle();
    @(negedge clk);
    while (cmd_backlog.size() != 0 || start || busy || replies_due.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_initial(logic [INIT_W-1:0] v);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    @(negedge clk);
  endtask

  task automatic push_random(int n, int w_wait, int w_sig, int w_close);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < w_wait) push_cmd(CMD_WAIT, ID_W'($urandom_range(0, 255)));
      else if (r < w_wait + w_sig) push_cmd(CMD_SIGNAL, ID_W'($urandom_range(0, 255)));
      else if (r < w_wait + w_sig + w_close)
        push_cmd(CMD_CLOSE, ID_W'($urandom_range(0, 255)));
      else push_cmd(CMD_READ, ID_W'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    logic [INIT_W-1:0] init_pick;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: basic flow at initial_count zero
    gaps_on = 1'b0;
    push_cmd(CMD_READ,   8'h00);
    push_cmd(CMD_SIGNAL, 8'h00);
    push_cmd(CMD_WAIT,   8'h11);
    push_cmd(CMD_WAIT,   8'h00);
    push_cmd(CMD_WAIT,   8'hFF);
    push_cmd(CMD_SIGNAL, 8'h00);
    push_cmd(CMD_WAIT,   8'hA5);
    push_cmd(CMD_CLOSE,  8'h00);
    push_cmd(CMD_CLOSE,  8'h00);
    settle();

    // directed: count at its maximum
    set_initial(15'h7FFF);
    push_cmd(CMD_CLOSE,  8'h00);
    push_cmd(CMD_SIGNAL, 8'h5A);
    push_cmd(CMD_WAIT,   8'h01);
    push_cmd(CMD_SIGNAL, 8'h00);
    push_cmd(CMD_READ,   8'hFF);
    settle();

    // random batches, each opened by a close to load the new initial_count
    for (int p = 0; p < 8; p++) begin
      case (p)
        0, 5:    init_pick = '0;
        1:       init_pick = 15'd1;
        2:       init_pick = 15'h7FFF;
        3, 6:    init_pick = INIT_W'($urandom_range(2, 3));
        4:       init_pick = INIT_W'($urandom_range(0, 32767));
        default: init_pick = 15'h7FFE;
      endcase
      set_initial(init_pick);
      gaps_on = p % 3 != 1;
      push_cmd(CMD_CLOSE, ID_W'($urandom_range(0, 255)));
      // even batches add 20 waits; at initial_count <= 3 they overflow the wait queue
      if (p % 2 == 0) push_random(20, 100, 0, 0);
      case (p % 4)
        0:       push_random(31, 55, 30, 5);
        1:       push_random(51, 40, 40, 8);
        2:       push_random(31, 25, 60, 5);
        default: push_random(51, 60, 25, 5);
      endcase
      settle();
    end

    repeat (20) @(posedge clk);
    $display("%0d commands, %0d replies: %0d proceed, %0d blocked, %0d signal releases,",
             cmds_taken, replies_seen, kind_seen[KIND_PROCEED], kind_seen[KIND_BLOCKED],
             kind_seen[KIND_REL_SIG]);
    $display("  %0d close releases, %0d signal done, %0d errors, %0d count reports",
             kind_seen[KIND_REL_CLOSE], kind_seen[KIND_SIG_DONE], kind_seen[KIND_ERROR],
             kind_seen[KIND_REPORT]);
    if (replies_due.size() != 0) begin
      $display("%0t: %0d replies never arrived", $time, replies_due.size());
      fails++;
    end
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
